// ===== sv/ffpd_pkg.sv =====
package ffpd_pkg;

    // character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_DIG_0   = 8'h30;
    localparam logic [7:0] CH_DIG_9   = 8'h39;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_F   = 8'h66;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] HEX_ALPHA_BASE = 8'd10;

    // name length handling
    localparam int          NAME_LEN_BITS    = 5;
    localparam logic [4:0]  NAME_LIMIT_RESET = 5'd30;
    localparam logic [4:0]  LENGTH_MAX       = 5'd31;

    // results per item and field index default
    localparam int RES_SLOTS            = 3;
    localparam int RES_CNT_BITS         = 2;
    localparam int FIELD_INDEX_BITS_DEF = 8;
    localparam int FIELD_NUM_BITS       = 8;

    typedef enum logic [1:0] {
        MARK_DATA      = 2'd0,
        MARK_NAME_END  = 2'd1,
        MARK_VALUE_END = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_HIGH = 2'd1,
        ESC_LOW  = 2'd2
    } t_esc_step;

    typedef struct packed {
        logic                     value_phase;
        t_esc_step                escape_step;
        logic [3:0]               high_nibble;
        logic                     escape_bad;
        logic [NAME_LEN_BITS-1:0] name_length;
        logic                     name_overflow;
    } t_parse_state;

    localparam t_parse_state PARSE_RESET = '{
        value_phase:   1'b0,
        escape_step:   ESC_IDLE,
        high_nibble:   4'd0,
        escape_bad:    1'b0,
        name_length:   5'd0,
        name_overflow: 1'b0
    };

    typedef struct packed {
        logic [7:0]                out_byte;
        t_mark                     mark;
        logic                      in_value;
        logic [FIELD_NUM_BITS-1:0] field_number;
        logic                      bad_escape;
        logic                      name_cut;
        logic                      final_res;
    } t_result;

endpackage

// ===== sv/ffpd_decode.sv =====
module ffpd_decode #(
    parameter int FIELD_INDEX_BITS = ffpd_pkg::FIELD_INDEX_BITS_DEF
) (
    input  logic [7:0]                       i_byte,
    input  logic                             i_last,
    input  ffpd_pkg::t_parse_state           i_state,
    input  logic [FIELD_INDEX_BITS-1:0]      i_field_cnt,
    input  logic [ffpd_pkg::NAME_LEN_BITS-1:0] i_name_limit,
    output ffpd_pkg::t_result                o_res [ffpd_pkg::RES_SLOTS],
    output logic [ffpd_pkg::RES_CNT_BITS-1:0] o_res_cnt,
    output ffpd_pkg::t_parse_state           o_state,
    output logic [FIELD_INDEX_BITS-1:0]      o_field_cnt
);
    import ffpd_pkg::*;

    // hex digit to nibble, top bit flags a non-hex digit
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        logic [7:0] v;
        r = 5'b1_0000;
        v = 8'd0;
        if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            v = c - CH_DIG_0;
            r = {1'b0, v[3:0]};
        end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
            v = c - CH_LOW_A + HEX_ALPHA_BASE;
            r = {1'b0, v[3:0]};
        end else if (c >= CH_UP_A && c <= CH_UP_F) begin
            v = c - CH_UP_A + HEX_ALPHA_BASE;
            r = {1'b0, v[3:0]};
        end
        return r;
    endfunction

    function automatic t_result mk_res(input logic [7:0] b, input t_mark m,
                                       input logic inv, input logic bad,
                                       input logic cut,
                                       input logic [FIELD_NUM_BITS-1:0] fnum);
        t_result r;
        r.out_byte     = b;
        r.mark         = m;
        r.in_value     = inv;
        r.field_number = fnum;
        r.bad_escape   = bad;
        r.name_cut     = cut;
        r.final_res    = 1'b0;
        return r;
    endfunction

    logic [FIELD_INDEX_BITS+FIELD_NUM_BITS-1:0] fnum_ext;
    logic [FIELD_NUM_BITS-1:0]                  fnum;
    t_parse_state                               st;
    t_result                                    res [RES_SLOTS];
    logic [RES_CNT_BITS-1:0]                    n;
    logic [FIELD_INDEX_BITS-1:0]                cnt;
    logic [4:0]                                 nib;

    // field index as seen on results, zero-extended or truncated
    assign fnum_ext = {{FIELD_NUM_BITS{1'b0}}, i_field_cnt};
    assign fnum     = fnum_ext[FIELD_NUM_BITS-1:0];

    // one pass over the byte: data, escape and marker results
    always_comb begin
        st  = i_state;
        cnt = i_field_cnt;
        n   = '0;
        nib = 5'd0;
        for (int k = 0; k < RES_SLOTS; k++) begin
            res[k] = '0;
        end

        if (!st.value_phase) begin
            if (i_byte == CH_EQUAL) begin
                res[n] = mk_res(8'd0, MARK_NAME_END, 1'b0, 1'b0, st.name_overflow, fnum);
                n = n + 1'b1;
                st.value_phase = 1'b1;
            end else if (st.name_length < i_name_limit) begin
                res[n] = mk_res(i_byte, MARK_DATA, 1'b0, 1'b0, 1'b0, fnum);
                n = n + 1'b1;
                if (st.name_length < LENGTH_MAX) begin
                    st.name_length = st.name_length + 1'b1;
                end
            end else begin
                st.name_overflow = 1'b1;
            end
        end else if (i_byte == CH_AMP) begin
            res[n] = mk_res(8'd0, MARK_VALUE_END, 1'b1, st.escape_step != ESC_IDLE,
                            1'b0, fnum);
            n = n + 1'b1;
            st  = PARSE_RESET;
            cnt = cnt + 1'b1;
        end else begin
            unique case (st.escape_step)
                ESC_IDLE: begin
                    if (i_byte == CH_PERCENT) begin
                        st.escape_step = ESC_HIGH;
                        st.escape_bad  = 1'b0;
                        st.high_nibble = 4'd0;
                    end else begin
                        res[n] = mk_res(i_byte, MARK_DATA, 1'b1, 1'b0, 1'b0, fnum);
                        n = n + 1'b1;
                    end
                end
                ESC_HIGH: begin
                    nib = hex_nibble(i_byte);
                    st.high_nibble = nib[3:0];
                    st.escape_bad  = st.escape_bad | nib[4];
                    st.escape_step = ESC_LOW;
                end
                default: begin
                    nib = hex_nibble(i_byte);
                    res[n] = mk_res({st.high_nibble, nib[3:0]}, MARK_DATA, 1'b1,
                                    st.escape_bad | nib[4], 1'b0, fnum);
                    n = n + 1'b1;
                    st.escape_step = ESC_IDLE;
                    st.high_nibble = 4'd0;
                    st.escape_bad  = 1'b0;
                end
            endcase
        end

        // end of input closes the open field and restarts the parser
        if (i_last) begin
            if (!st.value_phase && (st.name_length != '0 || st.name_overflow)) begin
                res[n] = mk_res(8'd0, MARK_NAME_END, 1'b0, 1'b0, st.name_overflow, fnum);
                n = n + 1'b1;
                st.value_phase = 1'b1;
            end
            if (st.value_phase) begin
                res[n] = mk_res(8'd0, MARK_VALUE_END, 1'b1, st.escape_step != ESC_IDLE,
                                1'b0, fnum);
                n = n + 1'b1;
            end
            if (n != '0) begin
                res[n - 1'b1].final_res = 1'b1;
            end
            st  = PARSE_RESET;
            cnt = '0;
        end
    end

    assign o_res       = res;
    assign o_res_cnt   = n;
    assign o_state     = st;
    assign o_field_cnt = cnt;

endmodule

// ===== sv/ffpd_out_buf.sv =====
module ffpd_out_buf (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  ffpd_pkg::t_result                 i_res [ffpd_pkg::RES_SLOTS],
    input  logic [ffpd_pkg::RES_CNT_BITS-1:0] i_res_cnt,
    output logic                              o_free,
    output logic                              o_valid,
    input  logic                              i_ready,
    output ffpd_pkg::t_result                 o_res
);
    import ffpd_pkg::*;

    t_result                 r_res [RES_SLOTS];
    logic [RES_CNT_BITS-1:0] r_cnt;
    logic [RES_CNT_BITS-1:0] r_idx;
    logic                    pop;

    // results still waiting are those from r_idx up to r_cnt
    assign o_valid = (r_idx != r_cnt);
    assign pop     = o_valid && i_ready;
    assign o_free  = !o_valid || (pop && ((r_idx + 1'b1) == r_cnt));

    // slot select for the output
    always_comb begin
        case (r_idx)
            2'd1:    o_res = r_res[1];
            2'd2:    o_res = r_res[2];
            default: o_res = r_res[0];
        endcase
    end

    // slot count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_res_cnt;
            r_idx <= '0;
        end else if (pop) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // result slots
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== sv/form_field_percent_decoder_unit.sv =====
// Form field percent decoder: parses a name=value&name=value byte stream.
// Input stream (s_axis): one raw byte per item in tdata, tlast on the final
// byte of the query string. Output stream (m_axis): one result per item,
// either a data byte or an end-of-name / end-of-value marker, with the field
// index in tdata and kind and error flags in tuser; tlast marks the last
// result caused by the final input byte.
// Configuration (cfg_*): writes the name length limit and is always ready;
// the user must see that it is written only while the block is idle; the
// block does not enforce this. A byte passes the input register, then the
// result slots. Throughput: one input byte per cycle while m_axis_tready is
// high and each byte yields at most one result. A byte yielding k results
// (up to 3) holds the input until they drain, since the single output port
// drains one result per cycle from a three-slot result register.
// Reset: the parser returns to the start of a name, the field counter to 0
// and the name limit to 30. After a tlast byte the parser restarts the same
// way, keeping the limit.
// Stall: while m_axis_tready is low the result register holds, the input
// register fills and s_axis_tready drops.
module form_field_percent_decoder_unit #(
    parameter int FIELD_INDEX_BITS = ffpd_pkg::FIELD_INDEX_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    // output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [15:8] field_number
    output logic [4:0]  m_axis_tuser,   // [1:0] mark, [2] in_value,
                                        // [3] bad_escape, [4] name_cut
    output logic        m_axis_tlast,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data        // [4:0] name_limit
);
    import ffpd_pkg::*;

    logic                        r_in_valid;
    logic [7:0]                  r_in_byte;
    logic                        r_in_last;
    t_parse_state                r_state;
    t_parse_state                n_state;
    logic [FIELD_INDEX_BITS-1:0] r_field_cnt;
    logic [FIELD_INDEX_BITS-1:0] n_field_cnt;
    logic [NAME_LEN_BITS-1:0]    r_name_limit;
    t_result                     dec_res [RES_SLOTS];
    logic [RES_CNT_BITS-1:0]     dec_cnt;
    logic                        buf_free;
    logic                        load;
    t_result                     out_res;

    // move the held byte into the result slots once they are drained
    assign load          = r_in_valid && buf_free;
    assign s_axis_tready = !r_in_valid || load;
    assign cfg_ready     = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // parser state and field counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PARSE_RESET;
            r_field_cnt <= '0;
        end else if (load) begin
            r_state     <= n_state;
            r_field_cnt <= n_field_cnt;
        end
    end

    // name limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit <= NAME_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            r_name_limit <= cfg_data;
        end
    end

    ffpd_decode #(
        .FIELD_INDEX_BITS(FIELD_INDEX_BITS)
    ) u_decode (
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .i_state     (r_state),
        .i_field_cnt (r_field_cnt),
        .i_name_limit(r_name_limit),
        .o_res       (dec_res),
        .o_res_cnt   (dec_cnt),
        .o_state     (n_state),
        .o_field_cnt (n_field_cnt)
    );

    ffpd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_res    (dec_res),
        .i_res_cnt(dec_cnt),
        .o_free   (buf_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (out_res)
    );

    // output packing
    assign m_axis_tdata = {out_res.field_number, out_res.out_byte};
    assign m_axis_tuser = {out_res.name_cut, out_res.bad_escape, out_res.in_value,
                           out_res.mark};
    assign m_axis_tlast = out_res.final_res;

    // the final result of a string always closes a value
    a_last_is_value_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (t_mark'(m_axis_tuser[1:0]) == MARK_VALUE_END))
        else $error("final result is not an end-of-value marker");

    // a final byte always yields at least one result
    a_last_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_last) |=> m_axis_tvalid)
        else $error("final byte produced no result");

    // the parser restarts after a final byte
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && r_in_last) |=> (r_state == PARSE_RESET && r_field_cnt == '0))
        else $error("parser state not restarted after final byte");

endmodule
